FILE: rtl/lssh_pkg.sv
// ----------------------------------------------------------------------------
// Limb shift-and-halve package
// Shared constants, register indexes and the mode encoding of the limb
// shift-and-halve block.
// ----------------------------------------------------------------------------
package lssh_pkg;

    // Default limb width in bits.
    localparam int unsigned LIMB_W = 64;

    // Configuration port widths.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 2'd1;

    // Number of result words the output queue holds.
    localparam int unsigned RQ_DEPTH = 4;

    // Operating modes. The unused code behaves as a shift.
    typedef enum logic [1:0] {
        MODE_SHIFT = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_SUB   = 2'd2
    } mode_t;

endpackage

FILE: rtl/lssh_datapath.sv
// ----------------------------------------------------------------------------
// Limb datapath
// Combines one input limb with the pending limb and carry to form the next
// state and up to two result words.
// ----------------------------------------------------------------------------
module lssh_datapath #(
    parameter int unsigned LIMB_WIDTH = lssh_pkg::LIMB_W
) (
    input  logic [1:0]                      mode,
    input  logic [$clog2(LIMB_WIDTH)-1:0]   shift_amount,
    input  logic [LIMB_WIDTH-1:0]           a_limb,
    input  logic [LIMB_WIDTH-1:0]           b_limb,
    input  logic [LIMB_WIDTH-1:0]           extra,
    input  logic                            first_limb,
    input  logic                            last_limb,
    input  logic [LIMB_WIDTH-1:0]           held_limb,
    input  logic [1:0]                      carry_or_borrow,
    input  logic [LIMB_WIDTH-1:0]           saved_low_bits,
    input  logic                            have_held,
    output logic [LIMB_WIDTH-1:0]           held_next,
    output logic [1:0]                      carry_next,
    output logic [LIMB_WIDTH-1:0]           saved_next,
    output logic [2*LIMB_WIDTH:0]           res_word0,
    output logic [2*LIMB_WIDTH:0]           res_word1,
    output logic [1:0]                      res_count
);
    import lssh_pkg::*;

    localparam int unsigned SW = $clog2(LIMB_WIDTH);
    localparam logic [SW:0] WIDTH_L = (SW+1)'(LIMB_WIDTH);

    logic                  start;
    logic [SW:0]           up_dist;
    logic [LIMB_WIDTH-1:0] cin;
    logic [LIMB_WIDTH-1:0] top_mask;
    logic [LIMB_WIDTH:0]   sum1;
    logic [LIMB_WIDTH:0]   sum2;
    logic [LIMB_WIDTH:0]   dif1;
    logic [LIMB_WIDTH:0]   dif2;
    logic [LIMB_WIDTH-1:0] mid_limb;
    logic [LIMB_WIDTH-1:0] top_limb;

    // A limb with no number in progress starts a new one.
    assign start = first_limb | ~have_held;

    // A shift of zero gives a distance equal to the limb width, so the
    // left shifts and the fill mask drop to zero and the limb passes as is.
    assign up_dist  = WIDTH_L - {1'b0, shift_amount};
    assign top_mask = {LIMB_WIDTH{1'b1}} << up_dist;

    assign cin  = start ? extra : {{(LIMB_WIDTH-2){1'b0}}, carry_or_borrow};
    assign sum1 = {1'b0, a_limb} + {1'b0, b_limb};
    assign sum2 = {1'b0, sum1[LIMB_WIDTH-1:0]} + {1'b0, cin};
    assign dif1 = {1'b0, a_limb} - {1'b0, b_limb};
    assign dif2 = {1'b0, dif1[LIMB_WIDTH-1:0]} - {1'b0, cin};

    always_comb
    begin
        held_next  = a_limb;
        carry_next = start ? 2'b00 : carry_or_borrow;
        saved_next = start ? (a_limb << up_dist) : saved_low_bits;
        mid_limb   = (held_limb >> shift_amount) | (a_limb << up_dist);
        top_limb   = (a_limb >> shift_amount) | (extra & top_mask);
        unique case (mode)
            MODE_ADD:
            begin
                held_next  = sum2[LIMB_WIDTH-1:0];
                carry_next = {1'b0, sum1[LIMB_WIDTH]} + {1'b0, sum2[LIMB_WIDTH]};
                saved_next = start ? {{(LIMB_WIDTH-1){1'b0}}, sum2[0]} : saved_low_bits;
                mid_limb   = {sum2[0], held_limb[LIMB_WIDTH-1:1]};
                top_limb   = {sum1[LIMB_WIDTH] ^ sum2[LIMB_WIDTH], sum2[LIMB_WIDTH-1:1]};
            end
            MODE_SUB:
            begin
                held_next  = dif2[LIMB_WIDTH-1:0];
                carry_next = {1'b0, dif1[LIMB_WIDTH]} + {1'b0, dif2[LIMB_WIDTH]};
                saved_next = start ? {{(LIMB_WIDTH-1){1'b0}}, dif2[0]} : saved_low_bits;
                mid_limb   = {dif2[0], held_limb[LIMB_WIDTH-1:1]};
                top_limb   = {dif1[LIMB_WIDTH] ^ dif2[LIMB_WIDTH], dif2[LIMB_WIDTH-1:1]};
            end
            default:
            begin
                // Shift mode; the defaults above already hold its values.
                held_next = a_limb;
            end
        endcase
    end

    // Word layout: result limb, shifted-out bits, final flag.
    assign res_word0 = start ? {top_limb, saved_next, 1'b1}
                             : {mid_limb, {LIMB_WIDTH{1'b0}}, 1'b0};
    assign res_word1 = {top_limb, saved_next, 1'b1};
    assign res_count = {1'b0, ~start} + {1'b0, last_limb};

endmodule

FILE: rtl/lssh_rq.sv
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two result words per cycle and
// presents one word per cycle at its head while the output is not stalled.
// ----------------------------------------------------------------------------
module lssh_rq #(
    parameter int unsigned LIMB_WIDTH = lssh_pkg::LIMB_W,
    parameter int unsigned DEPTH      = lssh_pkg::RQ_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            push_count,
    input  logic [2*LIMB_WIDTH:0] push_word0,
    input  logic [2*LIMB_WIDTH:0] push_word1,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [2*LIMB_WIDTH:0] out_word,
    output logic                  room
);
    import lssh_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned WW = 2 * LIMB_WIDTH + 1;

    logic [WW-1:0] q_reg  [DEPTH];
    logic [WW-1:0] q_next [DEPTH];
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] base;
    logic [CW-1:0] base_up;
    logic          pop;

    assign out_valid = (cnt_reg != '0);
    assign out_word  = q_reg[0];
    assign pop       = out_valid & ~out_stall;
    assign room      = (cnt_reg <= CW'(DEPTH - 2));

    // Slot where the first new word lands once the head has left.
    assign base     = cnt_reg - CW'(pop);
    assign base_up  = base + CW'(1);
    assign cnt_next = base + CW'(push_count);

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_slot
        logic [WW-1:0] kept;
        if (g < DEPTH - 1)
        begin : g_shift
            assign kept = pop ? q_reg[g+1] : q_reg[g];
        end
        else
        begin : g_end
            assign kept = q_reg[g];
        end
        assign q_next[g] = (push_count != 2'd0 && base == CW'(g))    ? push_word0 :
                           (push_count == 2'd2 && base_up == CW'(g)) ? push_word1 :
                           kept;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: rtl/limb_stream_shift_and_halve.sv
// An accepted word waits in the input register and is processed into the
// result queue once it has room. Throughput: one limb per cycle while the
// queue has room; a number of N limbs gives N words.
// The four-word result queue needs two free slots before a limb is processed.
// Reset: asynchronous, active low; clears pending state, mode to shift and
// the shift distance to one.
// ----------------------------------------------------------------------------
// Limb stream shift and halve
// Streams multi-limb numbers, least significant limb first, and returns them
// shifted right, or added or subtracted and then halved.
// ----------------------------------------------------------------------------
module limb_stream_shift_and_halve #(
    parameter int unsigned LIMB_WIDTH = lssh_pkg::LIMB_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lssh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lssh_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input limb channel.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [LIMB_WIDTH-1:0]              a_limb,
    input  logic [LIMB_WIDTH-1:0]              b_limb,
    input  logic [LIMB_WIDTH-1:0]              extra,
    input  logic                               first_limb,
    input  logic                               last_limb,
    // Result channel.
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [LIMB_WIDTH-1:0]              result_limb,
    output logic [LIMB_WIDTH-1:0]              shifted_out,
    output logic                               final_result
);
    import lssh_pkg::*;

    localparam int unsigned SW = $clog2(LIMB_WIDTH);

    // Configuration registers.
    logic [1:0]            mode_reg;
    logic [SW-1:0]         shift_reg;

    // Input register: one word waits here until the result queue has room.
    logic                  in_valid_reg;
    logic [LIMB_WIDTH-1:0] a_reg;
    logic [LIMB_WIDTH-1:0] b_reg;
    logic [LIMB_WIDTH-1:0] extra_reg;
    logic                  first_reg;
    logic                  last_reg;

    // Pending state of the number in progress.
    logic [LIMB_WIDTH-1:0] held_limb_reg;
    logic [1:0]            carry_reg;
    logic [LIMB_WIDTH-1:0] saved_reg;
    logic                  have_held_reg;

    logic [LIMB_WIDTH-1:0] held_next;
    logic [1:0]            carry_next;
    logic [LIMB_WIDTH-1:0] saved_next;
    logic [2*LIMB_WIDTH:0] res_word0;
    logic [2*LIMB_WIDTH:0] res_word1;
    logic [1:0]            res_count;
    logic [2*LIMB_WIDTH:0] out_word;
    logic                  room;
    logic                  proc;
    logic                  in_accept;

    // Configuration is always taken at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SHIFT;
            shift_reg <= SW'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[1:0];
                REG_SHIFT: shift_reg <= cfg_data[SW-1:0];
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    // The word in the input register is processed as soon as the queue can
    // take two results; a new word enters in the same cycle.
    assign proc      = in_valid_reg & room;
    assign in_stall  = in_valid_reg & ~room;
    assign in_accept = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_reg     <= a_limb;
            b_reg     <= b_limb;
            extra_reg <= extra;
            first_reg <= first_limb;
            last_reg  <= last_limb;
        end
    end

    lssh_datapath #(
        .LIMB_WIDTH (LIMB_WIDTH)
    ) u_datapath (
        .mode            (mode_reg),
        .shift_amount    (shift_reg),
        .a_limb          (a_reg),
        .b_limb          (b_reg),
        .extra           (extra_reg),
        .first_limb      (first_reg),
        .last_limb       (last_reg),
        .held_limb       (held_limb_reg),
        .carry_or_borrow (carry_reg),
        .saved_low_bits  (saved_reg),
        .have_held       (have_held_reg),
        .held_next       (held_next),
        .carry_next      (carry_next),
        .saved_next      (saved_next),
        .res_word0       (res_word0),
        .res_word1       (res_word1),
        .res_count       (res_count)
    );

    // The pending limb, carry and shifted-out bits advance with each
    // processed word; a last limb closes the number.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_limb_reg <= '0;
            carry_reg     <= '0;
            saved_reg     <= '0;
            have_held_reg <= 1'b0;
        end
        else if (proc)
        begin
            held_limb_reg <= held_next;
            carry_reg     <= carry_next;
            saved_reg     <= saved_next;
            have_held_reg <= ~last_reg;
        end
    end

    lssh_rq #(
        .LIMB_WIDTH (LIMB_WIDTH),
        .DEPTH      (RQ_DEPTH)
    ) u_rq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (proc ? res_count : 2'd0),
        .push_word0 (res_word0),
        .push_word1 (res_word1),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_word   (out_word),
        .room       (room)
    );

    assign result_limb  = out_word[2*LIMB_WIDTH:LIMB_WIDTH+1];
    assign shifted_out  = out_word[LIMB_WIDTH:1];
    assign final_result = out_word[0];

    // A processed word that yields results leaves the queue non-empty.
    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        proc && res_count != 2'd0 |=> out_valid)
        else $error("results pushed but queue empty");

    // Only the final word of a number carries shifted-out bits.
    a_low_bits_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !final_result |-> shifted_out == '0)
        else $error("shifted-out bits on a non-final word");

    // A last limb closes the number in progress.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        proc && last_reg |=> !have_held_reg)
        else $error("number still open after last limb");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Limb stream shift and halve testbench
// Streams multi-limb numbers through the block in every mode and at many shift
// distances, predicts each result word in the bench itself and compares every
// word the block returns against the oldest prediction. Both channels idle at
// random in three patterns, and the registers are rewritten between segments.
// ----------------------------------------------------------------------------
module tb_top;
    import lssh_pkg::*;

    localparam int unsigned W = LIMB_W;

    // Indexes that select no register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    // The unused mode code, which the block treats as a shift.
    localparam logic [1:0] MODE_CODE_SPARE = 2'd3;

    // A word accepted without a result is still processed out of the input
    // register, so this margin is plenty before the block can be called idle.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_LIMIT   = 50000;
    localparam int unsigned SEG_WORDS     = 105;
    localparam int unsigned SEGS_PER_PASS = 6;

    typedef struct {
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] x;
        logic         first;
        logic         last;
    } limb_word_t;

    typedef struct {
        logic [W-1:0] limb;
        logic [W-1:0] lost;
        logic         top;
    } result_word_t;

    // Every block input has a known value from time zero.
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic [W-1:0]          a_limb     = '0;
    logic [W-1:0]          b_limb     = '0;
    logic [W-1:0]          extra      = '0;
    logic                  first_limb = 1'b0;
    logic                  last_limb  = 1'b0;
    logic                  out_stall  = 1'b0;

    logic                  cfg_ready;
    logic                  in_stall;
    logic                  out_valid;
    logic [W-1:0]          result_limb;
    logic [W-1:0]          shifted_out;
    logic                  final_result;

    limb_stream_shift_and_halve #(
        .LIMB_WIDTH(LIMB_W)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .a_limb      (a_limb),
        .b_limb      (b_limb),
        .extra       (extra),
        .first_limb  (first_limb),
        .last_limb   (last_limb),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_limb (result_limb),
        .shifted_out (shifted_out),
        .final_result(final_result)
    );

    // Words waiting to be offered, and result words predicted but not yet seen.
    limb_word_t   limb_backlog[$];
    result_word_t pending_results[$];

    // Per-cycle idle chances, in percent, for the sender and the receiver.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int errors        = 0;
    int words_sent    = 0;
    int results_ok    = 0;
    int reg_writes    = 0;

    // Set at a rising edge when the word on the input channel was taken.
    logic in_taken = 1'b0;

    // Shadow of the block: its registers as last written and its carried state.
    logic [1:0]   shadow_mode  = MODE_SHIFT;
    logic [5:0]   shadow_shift = 6'd1;
    logic [W-1:0] held_word    = '0;
    logic [1:0]   held_carry   = '0;
    logic [W-1:0] low_bits     = '0;
    logic         in_number    = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out what one accepted limb word produces and queues it. A limb
    // result can only be formed once the next limb is known, so every word
    // past the first releases the limb held from the one before, and the last
    // word also releases the top limb together with the bits shifted out.
    task automatic predict_limb_results(input limb_word_t w);
        mode_t        m;
        logic [5:0]   s;
        logic         start;
        logic [W-1:0] cin;
        logic [W-1:0] cur;
        logic [W-1:0] diff;
        logic [W+1:0] sum;
        logic [1:0]   cry;
        result_word_t r;
        s     = shadow_shift;
        start = w.first || !in_number;
        cin   = start ? w.x : {{(W-2){1'b0}}, held_carry};
        // The spare mode code falls through to a plain shift.
        case (shadow_mode)
            MODE_ADD: m = MODE_ADD;
            MODE_SUB: m = MODE_SUB;
            default:  m = MODE_SHIFT;
        endcase
        case (m)
            MODE_ADD:
            begin
                // The carry out can reach two when the incoming carry is wide.
                sum = {2'b00, w.a} + {2'b00, w.b} + {2'b00, cin};
                cur = sum[W-1:0];
                cry = sum[W+1:W];
                if (start)
                    low_bits = {{(W-1){1'b0}}, cur[0]};
            end
            MODE_SUB:
            begin
                diff = w.a - w.b;
                cur  = diff - cin;
                cry  = {1'b0, (w.b > w.a)} + {1'b0, (cin > diff)};
                if (start)
                    low_bits = {{(W-1){1'b0}}, cur[0]};
            end
            default:
            begin
                cur = w.a;
                cry = start ? 2'd0 : held_carry;
                if (start)
                    low_bits = (s == 0) ? '0 : (w.a << (W - s));
            end
        endcase

        if (!start)
        begin
            if (m != MODE_SHIFT)
                r.limb = (held_word >> 1) | (cur << (W - 1));
            else if (s == 0)
                r.limb = held_word;
            else
                r.limb = (held_word >> s) | (cur << (W - s));
            r.lost = '0;
            r.top  = 1'b0;
            pending_results.push_back(r);
        end

        held_word  = cur;
        held_carry = cry;

        if (w.last)
        begin
            // Only bit zero of a carry or borrow of two reaches the top bit.
            if (m != MODE_SHIFT)
                r.limb = (held_word >> 1) | ({{(W-1){1'b0}}, held_carry[0]} << (W - 1));
            else if (s == 0)
                r.limb = held_word;
            else
                r.limb = (held_word >> s) | (w.x & ({W{1'b1}} << (W - s)));
            r.lost = low_bits;
            r.top  = 1'b1;
            pending_results.push_back(r);
            in_number = 1'b0;
        end
        else
        begin
            in_number = 1'b1;
        end
    endtask

    // Driver: new values go out on the falling edge. A word stays on the
    // channel until the rising edge that takes it; the sender only pauses
    // between words, never in the middle of one.
    always @(negedge clk)
    begin : drive_words
        limb_word_t w;
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (!in_valid || in_taken)
            begin
                if (limb_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    w = limb_backlog.pop_front();
                    in_valid   <= 1'b1;
                    a_limb     <= w.a;
                    b_limb     <= w.b;
                    extra      <= w.x;
                    first_limb <= w.first;
                    last_limb  <= w.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: both channels are sampled on the rising edge. Accepted limb
    // words feed the predictor; accepted result words are checked field by
    // field against the oldest prediction.
    always @(posedge clk)
    begin : watch_channels
        result_word_t want;
        in_taken <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_limb_results('{a_limb, b_limb, extra, first_limb, last_limb});
                words_sent++;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result word with none expected: limb %h shifted_out %h final %b",
                             $time, result_limb, shifted_out, final_result);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result_limb !== want.limb)
                    begin
                        $display("%0t: result_limb expected %h actual %h",
                                 $time, want.limb, result_limb);
                        errors++;
                    end
                    if (shifted_out !== want.lost)
                    begin
                        $display("%0t: shifted_out expected %h actual %h",
                                 $time, want.lost, shifted_out);
                        errors++;
                    end
                    if (final_result !== want.top)
                    begin
                        $display("%0t: final_result expected %b actual %b",
                                 $time, want.top, final_result);
                        errors++;
                    end
                    results_ok++;
                end
            end
        end
    end

    // One register write over the configuration channel. The shadow copy is
    // updated at the edge that completes the handshake.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MODE:  shadow_mode  = val[1:0];
            REG_SHIFT: shadow_shift = val[5:0];
            default:   ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // The bits above each field are filled at random; the block keeps only
    // the field itself.
    task automatic write_mode(input logic [1:0] code);
        logic [CFG_DATA_W-1:0] v;
        v      = CFG_DATA_W'($urandom);
        v[1:0] = code;
        write_reg(REG_MODE, v);
    endtask

    task automatic write_shift(input logic [5:0] amount);
        logic [CFG_DATA_W-1:0] v;
        v      = CFG_DATA_W'($urandom);
        v[5:0] = amount;
        write_reg(REG_SHIFT, v);
    endtask

    // Waits until every word has gone in and every predicted result has come
    // back, then lets the block finish any word that produced no result.
    task automatic settle();
        int n;
        n = 0;
        while ((limb_backlog.size() != 0 || in_valid || pending_results.size() != 0)
               && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected result words never arrived",
                     $time, pending_results.size());
            errors++;
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_word(input logic [W-1:0] a, input logic [W-1:0] b,
                              input logic [W-1:0] x, input logic f, input logic l);
        limb_word_t w;
        w = '{a, b, x, f, l};
        limb_backlog.push_back(w);
    endtask

    // Limb values lean toward the edges: zero, all ones, lone top or low bit.
    function automatic logic [W-1:0] pick_limb();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(W-1){1'b0}}};
            3:       return {{(W-1){1'b0}}, 1'b1};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // A well-formed number of n limbs. The word with the first limb carries
    // a carry or borrow, mostly small; the last carries a fill word. An open
    // number stops before its last limb and is left in progress.
    task automatic queue_number(input int n, input bit open);
        logic [W-1:0] x;
        for (int i = 0; i < n; i++)
        begin
            if (i == 0)
            begin
                case ($urandom_range(4))
                    0:       x = '0;
                    1:       x = {{(W-1){1'b0}}, 1'b1};
                    2:       x = {{(W-2){1'b0}}, 2'b10};
                    default: x = pick_limb();
                endcase
            end
            else
            begin
                x = pick_limb();
            end
            queue_word(pick_limb(), pick_limb(), x, (i == 0), (i == n - 1) && !open);
        end
    endtask

    // One random segment: a fresh setting, then mostly complete numbers with
    // a sprinkling of stray words whose flags are random.
    task automatic random_segment(input int count);
        int r;
        int target;
        logic [5:0] amount;
        r = $urandom_range(9);
        if (r < 3)
            write_mode(MODE_SHIFT);
        else if (r < 6)
            write_mode(MODE_ADD);
        else if (r < 9)
            write_mode(MODE_SUB);
        else
            write_mode(MODE_CODE_SPARE);
        case ($urandom_range(7))
            0:       amount = 6'd0;
            1:       amount = 6'd1;
            2:       amount = 6'd63;
            default: amount = 6'($urandom_range(63));
        endcase
        write_shift(amount);
        if ($urandom_range(7) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                      CFG_DATA_W'($urandom));

        target = limb_backlog.size() + count;
        while (limb_backlog.size() < target)
        begin
            r = $urandom_range(99);
            if (r < 8)
                queue_word(pick_limb(), pick_limb(), pick_limb(),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
            else if (r < 90)
                queue_number($urandom_range(1, 4), ($urandom_range(15) == 0));
            else
                queue_number($urandom_range(5, 10), ($urandom_range(15) == 0));
        end
        settle();
    endtask

    initial
    begin : run_test
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, first under the reset setting: shift right by one.
        send_idle_pct = 6;
        recv_idle_pct = 51;
        queue_word('1, '0, '0, 1'b1, 1'b0);
        queue_word('0, '0, '0, 1'b0, 1'b0);
        queue_word({1'b1, {(W-1){1'b0}}}, '0, '1, 1'b0, 1'b1);
        // A number of one limb gives only its final result.
        queue_word({{(W-1){1'b0}}, 1'b1}, '0, '0, 1'b1, 1'b1);
        settle();

        // A shift of zero copies the limbs and ignores the fill word.
        write_shift(6'd0);
        queue_word({$urandom, $urandom}, '0, '1, 1'b1, 1'b0);
        queue_word({$urandom, $urandom}, '0, '1, 1'b0, 1'b1);
        settle();

        // The widest shift.
        write_shift(6'd63);
        queue_word('1, '0, '0, 1'b1, 1'b0);
        queue_word('1, '0, '1, 1'b0, 1'b1);
        settle();

        // All ones plus all ones plus an all-ones carry in leaves a carry of
        // two, of which only bit zero reaches the top.
        write_mode(MODE_ADD);
        queue_word('1, '1, '1, 1'b1, 1'b0);
        queue_word('1, '1, '0, 1'b0, 1'b1);
        queue_word('1, '0, {{(W-1){1'b0}}, 1'b1}, 1'b1, 1'b1);
        settle();

        // Zero minus all ones minus an all-ones borrow gives a borrow of two.
        write_mode(MODE_SUB);
        queue_word('0, '1, '1, 1'b1, 1'b0);
        queue_word('0, '1, '0, 1'b0, 1'b1);
        settle();

        // The spare mode code acts as a shift. A word without the first flag
        // and nothing in progress starts a number; a new first limb in the
        // middle of a number drops the limb that was held.
        write_mode(MODE_CODE_SPARE);
        write_shift(6'd5);
        queue_word({$urandom, $urandom}, '0, '1, 1'b0, 1'b0);
        queue_word({$urandom, $urandom}, '0, '1, 1'b0, 1'b1);
        queue_word({$urandom, $urandom}, '0, '0, 1'b1, 1'b0);
        queue_word({$urandom, $urandom}, '0, '0, 1'b1, 1'b0);
        queue_word({$urandom, $urandom}, '0, '1, 1'b0, 1'b1);
        // Leave a number open across a register change.
        queue_word({$urandom, $urandom}, '0, '0, 1'b1, 1'b0);
        settle();
        write_shift(6'd32);
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        queue_word({$urandom, $urandom}, '0, '1, 1'b0, 1'b1);
        settle();

        // Random part in three idle patterns: a mostly busy sender with a
        // choppy receiver, the reverse, then both flat out.
        for (int pass = 0; pass < 3; pass++)
        begin
            case (pass)
                0:
                begin
                    send_idle_pct = 6;
                    recv_idle_pct = 51;
                end
                1:
                begin
                    send_idle_pct = 51;
                    recv_idle_pct = 6;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < SEGS_PER_PASS; seg++)
                random_segment(SEG_WORDS);
        end

        settle();
        repeat (20) @(posedge clk);

        $display("Run covered %0d limb words and %0d checked result words over %0d register writes,",
                 words_sent, results_ok, reg_writes);
        $display("in shift, add and subtract modes under three idle patterns; %0d mismatches.",
                 errors);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Far beyond the slowest correct run; a hang anywhere ends here.
    initial
    begin : watchdog
        #5000000;
        $display("Run timed out with %0d result words still expected", pending_results.size());
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/lssh_pkg.sv
rtl/lssh_datapath.sv
rtl/lssh_rq.sv
rtl/limb_stream_shift_and_halve.sv
bench/tb_top.sv
